FILE: hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    // command codes on the operation field
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // reset value of the per-delay tick count
    localparam logic [15:0] DELAY_RESET = 16'd100;

    // one classified tick on its way from the front to the sequencer
    typedef struct packed {
        logic       cmd;
        logic [1:0] op;
        logic [7:0] load_byte;
        logic       ack;
        logic       sda;
    } tick_t;

    // one result tick
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
    } res_t;

endpackage

FILE: hw/rtl/i2cm_fifo.sv
`timescale 1ns / 1ps

module i2cm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    // status flags
    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill-level update, pointers wrap at the last entry
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       cmd_valid,
    input  logic [1:0] operation,
    input  logic [7:0] write_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output tick_t      tick
);

    // classify the request: shift register load value depends on the command
    always_comb
    begin
        tick.cmd = cmd_valid;
        tick.op  = operation;
        tick.ack = send_ack;
        tick.sda = sda_in;
        case (operation)
            OP_WRITE: tick.load_byte = write_byte;
            default:  tick.load_byte = 8'h00;
        endcase
    end

endmodule

FILE: hw/rtl/i2cm_seq.sv
`timescale 1ns / 1ps

module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] delay_ticks,
    input  logic        tick_valid,
    input  tick_t       tick,
    output logic        tick_pop,
    input  logic        res_full,
    output logic        res_push,
    output res_t        res
);

    // line phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ST1    = 4'd1;
    localparam logic [3:0] PH_ST2    = 4'd2;
    localparam logic [3:0] PH_ST3    = 4'd3;
    localparam logic [3:0] PH_SP1    = 4'd4;
    localparam logic [3:0] PH_SP2    = 4'd5;
    localparam logic [3:0] PH_SP3    = 4'd6;
    localparam logic [3:0] PH_WR_HI  = 4'd7;
    localparam logic [3:0] PH_WR_LO  = 4'd8;
    localparam logic [3:0] PH_RD_HI  = 4'd9;
    localparam logic [3:0] PH_RD_SMP = 4'd10;
    localparam logic [3:0] PH_ACK_HI = 4'd11;
    localparam logic [3:0] PH_ACK_LO = 4'd12;

    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [3:0]  bit_count_reg;
    logic [3:0]  bit_count_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic [15:0] delay_count_reg;
    logic [15:0] delay_count_next;
    logic        ack_choice_reg;
    logic        ack_choice_next;
    logic        scl_reg;
    logic        scl_next;
    logic        sda_reg;
    logic        sda_next;
    logic [15:0] delay_load;
    logic        step;
    logic        done;
    logic [7:0]  rdata;

    // one tick per cycle while a tick waits and the result queue has room
    assign step     = tick_valid && !res_full;
    assign tick_pop = step;
    assign res_push = step;

    // a zero delay counts as one tick
    assign delay_load = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;

    // next line state for the current tick
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        ack_choice_next  = ack_choice_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        done             = 1'b0;
        rdata            = 8'h00;
        if (phase_reg == PH_IDLE)
        begin
            // new command launches its first line change at once
            if (tick.cmd)
            begin
                delay_count_next = delay_load;
                case (tick.op)
                    OP_START:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_ST1;
                    end
                    OP_STOP:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_SP1;
                    end
                    OP_WRITE:
                    begin
                        shift_next     = tick.load_byte;
                        bit_count_next = 4'd0;
                        sda_next       = tick.load_byte[7];
                        phase_next     = PH_WR_HI;
                    end
                    default:
                    begin
                        shift_next      = tick.load_byte;
                        bit_count_next  = 4'd0;
                        ack_choice_next = tick.ack;
                        sda_next        = 1'b1;
                        phase_next      = PH_RD_HI;
                    end
                endcase
            end
        end
        else if (delay_count_reg > 16'd1)
        begin
            delay_count_next = delay_count_reg - 16'd1;
        end
        else
        begin
            // delay expired: next group of line changes
            delay_count_next = 16'd0;
            case (phase_reg)
                PH_ST1:
                begin
                    scl_next = 1'b1; phase_next = PH_ST2; delay_count_next = delay_load;
                end
                PH_ST2:
                begin
                    sda_next = 1'b0; phase_next = PH_ST3; delay_count_next = delay_load;
                end
                PH_ST3:
                begin
                    scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                end
                PH_SP1:
                begin
                    sda_next = 1'b0; phase_next = PH_SP2; delay_count_next = delay_load;
                end
                PH_SP2:
                begin
                    scl_next = 1'b1; phase_next = PH_SP3; delay_count_next = delay_load;
                end
                PH_SP3:
                begin
                    sda_next = 1'b1; phase_next = PH_IDLE; done = 1'b1;
                end
                PH_WR_HI, PH_RD_HI, PH_ACK_HI:
                begin
                    scl_next         = 1'b1;
                    delay_count_next = delay_load;
                    case (phase_reg)
                        PH_WR_HI: phase_next = PH_WR_LO;
                        PH_RD_HI: phase_next = PH_RD_SMP;
                        default:  phase_next = PH_ACK_LO;
                    endcase
                end
                PH_WR_LO:
                begin
                    // eight data bits, then sda is released for the ack clock
                    scl_next       = 1'b0;
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_next < 4'd8)
                    begin
                        shift_next       = {shift_reg[6:0], 1'b0};
                        sda_next         = shift_reg[6];
                        phase_next       = PH_WR_HI;
                        delay_count_next = delay_load;
                    end
                    else if (bit_count_next == 4'd8)
                    begin
                        sda_next         = 1'b1;
                        phase_next       = PH_WR_HI;
                        delay_count_next = delay_load;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_RD_SMP:
                begin
                    // sample at the end of the high phase
                    shift_next       = {shift_reg[6:0], tick.sda};
                    scl_next         = 1'b0;
                    bit_count_next   = bit_count_reg + 4'd1;
                    delay_count_next = delay_load;
                    if (bit_count_next < 4'd8)
                    begin
                        phase_next = PH_RD_HI;
                    end
                    else
                    begin
                        sda_next   = !ack_choice_reg;
                        phase_next = PH_ACK_HI;
                    end
                end
                PH_ACK_LO:
                begin
                    // nack leaves scl released high
                    scl_next   = !ack_choice_reg;
                    if (ack_choice_reg)
                    begin
                        sda_next = 1'b1;
                    end
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                    rdata      = shift_reg;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result of this tick
    always_comb
    begin
        res.scl   = scl_next;
        res.sda   = sda_next;
        res.busy  = (phase_next != PH_IDLE);
        res.done  = done;
        res.rdata = rdata;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'h00;
            delay_count_reg <= 16'd0;
            ack_choice_reg  <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            ack_choice_reg  <= ack_choice_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
        end
    end

endmodule

FILE: hw/rtl/i2c_master_bit_engine_unit.sv
`timescale 1ns / 1ps

// I2C master line sequencer. Each pushed request is one line tick (optional command plus
// the sampled SDA level) and yields exactly one result with the driven SCL/SDA levels,
// busy, done and the read byte. Throughput is one request per cycle while the result
// queue has room: the sequencer advances its phase and delay counter once per request,
// and the input and result queues let either side stall without loss. A request is
// queued before the sequencer handles it. Commands offered while busy are dropped;
// cfg_wr_data sets the ticks per line delay (zero acts as one) and resets to 100.
module i2c_master_bit_engine_unit
    import i2cm_pkg::*;
#(
    parameter int TICK_DEPTH = 4,
    parameter int RES_DEPTH  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd_valid,
    input  logic [1:0]  operation,
    input  logic [7:0]  write_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        cmd_done,
    output logic [7:0]  read_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] delay_ticks_reg;
    tick_t       tick_in;
    tick_t       tick_out;
    logic        tick_empty;
    logic        tick_pop;
    res_t        res_in;
    res_t        res_out;
    logic        res_full;
    logic        res_push;

    // delay configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_ticks_reg <= cfg_wr_data;
        end
    end

    // request classification
    i2cm_front u_front (
        .cmd_valid  (cmd_valid),
        .operation  (operation),
        .write_byte (write_byte),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .tick       (tick_in)
    );

    // queue between front and sequencer
    i2cm_fifo #(
        .WIDTH ($bits(tick_t)),
        .DEPTH (TICK_DEPTH)
    ) u_tick_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (tick_in),
        .full      (full),
        .pop       (tick_pop),
        .pop_data  (tick_out),
        .empty     (tick_empty)
    );

    // line sequencer
    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .delay_ticks (delay_ticks_reg),
        .tick_valid  (!tick_empty),
        .tick        (tick_out),
        .tick_pop    (tick_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_in)
    );

    // result queue
    i2cm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    // result ports
    assign scl_out   = res_out.scl;
    assign sda_out   = res_out.sda;
    assign busy_res  = res_out.busy;
    assign cmd_done  = res_out.done;
    assign read_data = res_out.rdata;

    // sequencer never writes into a full result queue
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed while queue full");

    // an accepted request is always waiting for the sequencer on the next cycle
    a_tick_present: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !tick_empty)
        else $error("accepted request lost");

    // a completion never reports busy, and read data only comes with completion
    a_done_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!(res_in.done && res_in.busy) && (res_in.rdata == 8'h00 || res_in.done)))
        else $error("inconsistent completion result");

endmodule

FILE: dv/i2c_line_checker.sv
`timescale 1ns / 1ps

module i2c_line_checker
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        cmd_valid,
    input  logic [1:0]  operation,
    input  logic [7:0]  write_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    input  logic        empty,
    input  logic        pop,
    input  logic        scl_out,
    input  logic        sda_out,
    input  logic        busy_res,
    input  logic        cmd_done,
    input  logic [7:0]  read_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          fail_count,
    output int          outstanding,
    output logic        line_busy
);

    // sequencer phases of the line model
    typedef enum logic [3:0] {
        LN_IDLE,
        LN_ST1,
        LN_ST2,
        LN_ST3,
        LN_SP1,
        LN_SP2,
        LN_SP3,
        LN_WR_HI,
        LN_WR_LO,
        LN_RD_HI,
        LN_RD_SMP,
        LN_ACK_HI,
        LN_ACK_LO
    } line_phase_e;

    // line model state
    line_phase_e ph;
    logic [3:0]  bits_done;
    logic [7:0]  shifter;
    logic [15:0] hold_count;
    logic        ack_sel;
    logic        scl_lvl;
    logic        sda_lvl;
    logic [15:0] tick_delay;

    res_t expected_lines[$];
    int   errors;

    // a zero delay acts as one tick
    function automatic logic [15:0] hold_reload();
        return (tick_delay == 16'd0) ? 16'd1 : tick_delay;
    endfunction

    // advance the line model by one tick and form its result
    task automatic step_line(
        input  logic       cv,
        input  logic [1:0] op,
        input  logic [7:0] wb,
        input  logic       ack,
        input  logic       sda,
        output res_t       r
    );
        logic       done;
        logic [7:0] rdata;
        done  = 1'b0;
        rdata = 8'h00;
        if (ph == LN_IDLE)
        begin
            if (cv)
            begin
                case (op)
                    OP_START:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                        ph = LN_ST1;
                    end
                    OP_STOP:
                    begin
                        scl_lvl = 1'b0;
                        ph = LN_SP1;
                    end
                    OP_WRITE:
                    begin
                        shifter = wb;
                        bits_done = 4'd0;
                        sda_lvl = wb[7];
                        ph = LN_WR_HI;
                    end
                    default:
                    begin
                        shifter = 8'h00;
                        bits_done = 4'd0;
                        ack_sel = ack;
                        sda_lvl = 1'b1;
                        ph = LN_RD_HI;
                    end
                endcase
                hold_count = hold_reload();
            end
        end
        else if (hold_count > 16'd1)
        begin
            hold_count = hold_count - 16'd1;
        end
        else
        begin
            hold_count = 16'd0;
            case (ph)
                LN_ST1:
                begin
                    scl_lvl = 1'b1;
                    hold_count = hold_reload();
                    ph = LN_ST2;
                end
                LN_ST2:
                begin
                    sda_lvl = 1'b0;
                    hold_count = hold_reload();
                    ph = LN_ST3;
                end
                LN_ST3:
                begin
                    scl_lvl = 1'b0;
                    ph = LN_IDLE;
                    done = 1'b1;
                end
                LN_SP1:
                begin
                    sda_lvl = 1'b0;
                    hold_count = hold_reload();
                    ph = LN_SP2;
                end
                LN_SP2:
                begin
                    scl_lvl = 1'b1;
                    hold_count = hold_reload();
                    ph = LN_SP3;
                end
                LN_SP3:
                begin
                    sda_lvl = 1'b1;
                    ph = LN_IDLE;
                    done = 1'b1;
                end
                LN_WR_HI:
                begin
                    scl_lvl = 1'b1;
                    hold_count = hold_reload();
                    ph = LN_WR_LO;
                end
                LN_WR_LO:
                begin
                    scl_lvl = 1'b0;
                    bits_done = bits_done + 4'd1;
                    if (bits_done < 4'd8)
                    begin
                        shifter = shifter << 1;
                        sda_lvl = shifter[7];
                        hold_count = hold_reload();
                        ph = LN_WR_HI;
                    end
                    else if (bits_done == 4'd8)
                    begin
                        // release sda for the ack clock, the ack itself is ignored
                        sda_lvl = 1'b1;
                        hold_count = hold_reload();
                        ph = LN_WR_HI;
                    end
                    else
                    begin
                        ph = LN_IDLE;
                        done = 1'b1;
                    end
                end
                LN_RD_HI:
                begin
                    scl_lvl = 1'b1;
                    hold_count = hold_reload();
                    ph = LN_RD_SMP;
                end
                LN_RD_SMP:
                begin
                    shifter = {shifter[6:0], sda};
                    scl_lvl = 1'b0;
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= 4'd8)
                    begin
                        sda_lvl = ack_sel ? 1'b0 : 1'b1;
                        ph = LN_ACK_HI;
                    end
                    else
                    begin
                        ph = LN_RD_HI;
                    end
                    hold_count = hold_reload();
                end
                LN_ACK_HI:
                begin
                    scl_lvl = 1'b1;
                    hold_count = hold_reload();
                    ph = LN_ACK_LO;
                end
                LN_ACK_LO:
                begin
                    // after a nack scl stays released, after an ack sda is released
                    if (ack_sel)
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b1;
                    end
                    else
                    begin
                        scl_lvl = 1'b1;
                    end
                    ph = LN_IDLE;
                    done = 1'b1;
                    rdata = shifter;
                end
                default:
                begin
                    ph = LN_IDLE;
                end
            endcase
        end
        r.scl   = scl_lvl;
        r.sda   = sda_lvl;
        r.busy  = (ph != LN_IDLE);
        r.done  = done;
        r.rdata = rdata;
    endtask

    // compare one result field
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // watch both queues, predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        res_t next_res;
        if (!rst_n)
        begin
            ph          = LN_IDLE;
            bits_done   = 4'd0;
            shifter     = 8'h00;
            hold_count  = 16'd0;
            ack_sel     = 1'b0;
            scl_lvl     = 1'b1;
            sda_lvl     = 1'b1;
            tick_delay  = DELAY_RESET;
            errors      = 0;
            expected_lines.delete();
            fail_count  <= 0;
            outstanding <= 0;
            line_busy   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                tick_delay = cfg_wr_data;

            // results first, a request never leaves in the cycle it enters
            if (pop && !empty)
            begin
                got = {scl_out, sda_out, busy_res, cmd_done, read_data};
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: result expected none actual %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("scl_out", 8'(want.scl), 8'(got.scl));
                    check_field("sda_out", 8'(want.sda), 8'(got.sda));
                    check_field("busy_res", 8'(want.busy), 8'(got.busy));
                    check_field("cmd_done", 8'(want.done), 8'(got.done));
                    check_field("read_data", want.rdata, got.rdata);
                end
            end

            if (push && !full)
            begin
                step_line(cmd_valid, operation, write_byte, send_ack, sda_in, next_res);
                expected_lines.push_back(next_res);
            end

            fail_count  <= errors;
            outstanding <= expected_lines.size();
            line_busy   <= (ph != LN_IDLE);
        end
    end

endmodule

FILE: dv/i2c_master_bit_engine_unit_test.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_unit_test;
    import i2cm_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        cmd_valid;
    logic [1:0]  operation;
    logic [7:0]  write_byte;
    logic        send_ack;
    logic        sda_in;
    logic        empty;
    logic        pop;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        cmd_done;
    logic [7:0]  read_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          fail_count;
    int          outstanding;
    logic        line_busy;
    logic        stall_off;
    logic [7:0]  pop_pattern;
    logic [5:0]  pattern_age;
    int          idle_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    i2c_master_bit_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_valid  (cmd_valid),
        .operation  (operation),
        .write_byte (write_byte),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .empty      (empty),
        .pop        (pop),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .cmd_done   (cmd_done),
        .read_data  (read_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    i2c_line_checker line_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_valid  (cmd_valid),
        .operation  (operation),
        .write_byte (write_byte),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .empty      (empty),
        .pop        (pop),
        .scl_out    (scl_out),
        .sda_out    (sda_out),
        .busy_res   (busy_res),
        .cmd_done   (cmd_done),
        .read_data  (read_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .line_busy  (line_busy)
    );

    // result side stalls on a rotating pattern that is redrawn now and then, unless stall_off is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop         <= 1'b0;
            pop_pattern <= 8'hFF;
            pattern_age <= 6'd0;
        end
        else if (stall_off)
        begin
            pop <= 1'b1;
        end
        else
        begin
            pattern_age <= pattern_age + 6'd1;
            if (pattern_age == 6'd63)
                pop_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            else
                pop_pattern <= {pop_pattern[0], pop_pattern[7:1]};
            pop <= pop_pattern[0];
        end
    end

    // watchdog on cycles with no request, result or register write
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("i2c_master_bit_engine_unit_test NOT OK");
                $finish;
            end
        end
    end

    // offer one request and hold it until accepted
    task automatic send_tick(
        input logic       cv,
        input logic [1:0] op,
        input logic [7:0] wb,
        input logic       ack,
        input logic       sda
    );
        push       <= 1'b1;
        cmd_valid  <= cv;
        operation  <= op;
        write_byte <= wb;
        send_ack   <= ack;
        sda_in     <= sda;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // idle ticks until the sequencer is done, then wait for all results
    task automatic quiet(input logic sda_fixed, input bit sda_random);
        push <= 1'b0;
        @(posedge clk);
        while (line_busy)
            send_tick(1'b0, OP_START, 8'h00, 1'b0,
                      sda_random ? 1'($urandom_range(0, 1)) : sda_fixed);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // register write while nothing is in flight
    task automatic set_delay(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random requests in bursts with random gaps
    task automatic random_run(input int n_items);
        int         sent;
        int         burst;
        int         gap;
        logic [7:0] wb;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       wb = 8'h00;
                    1:       wb = 8'hFF;
                    default: wb = 8'($urandom);
                endcase
                send_tick($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)), wb,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            sent += burst;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        quiet(1'b0, 1'b1);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        cmd_valid   = 1'b0;
        operation   = OP_START;
        write_byte  = 8'h00;
        send_ack    = 1'b0;
        sda_in      = 1'b1;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'd0;
        stall_off   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset delay value with a start condition
        send_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b1);
        quiet(1'b0, 1'b1);

        // zero delay acts as one: every command and its corner cases
        set_delay(16'd0);
        send_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b0);
        quiet(1'b0, 1'b1);
        send_tick(1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0);
        quiet(1'b0, 1'b1);
        send_tick(1'b1, OP_WRITE, 8'h00, 1'b1, 1'b1);
        quiet(1'b1, 1'b1);
        // read with ack while sda stays high
        send_tick(1'b1, OP_READ, 8'h00, 1'b1, 1'b1);
        quiet(1'b1, 1'b0);
        // read with nack while sda stays low
        send_tick(1'b1, OP_READ, 8'hFF, 1'b0, 1'b0);
        quiet(1'b0, 1'b0);
        // stop, then a command offered while busy
        send_tick(1'b1, OP_STOP, 8'h00, 1'b0, 1'b1);
        send_tick(1'b1, OP_WRITE, 8'hA5, 1'b1, 1'b0);
        quiet(1'b0, 1'b1);

        // random phases over several delays
        set_delay(16'd1);
        random_run(200);
        set_delay(16'd2);
        random_run(175);
        set_delay(16'd3);
        random_run(175);

        // wide delay with one start, no idling on either side
        stall_off <= 1'b1;
        set_delay(16'h0100);
        send_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b1);
        quiet(1'b0, 1'b1);
        stall_off <= 1'b0;

        set_delay(16'($urandom_range(1, 7)));
        random_run(175);
        set_delay(16'd4);
        random_run(125);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("i2c_master_bit_engine_unit_test OK");
        else
            $display("i2c_master_bit_engine_unit_test NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_fifo.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_master_bit_engine_unit.sv
dv/i2c_line_checker.sv
dv/i2c_master_bit_engine_unit_test.sv
